// File: hdl/hfcd_pkg.sv
// Shared types, constants and helper functions for the humidity frame CRC decoder.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package hfcd_pkg;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // byte positions inside the six-byte frame
   localparam logic [2:0] POS_T_HI  = 3'd0;
   localparam logic [2:0] POS_T_LO  = 3'd1;
   localparam logic [2:0] POS_T_CRC = 3'd2;
   localparam logic [2:0] POS_H_HI  = 3'd3;
   localparam logic [2:0] POS_H_LO  = 3'd4;
   localparam logic [2:0] POS_H_CRC = 3'd5;

   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [13:0] HUM_SCALE   = 14'd10000;

   localparam int TEMP_MIN = -4500;
   localparam int TEMP_MAX = 13000;
   localparam int HUM_MAX  = 10000;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TEMP_CRC = 2'd1,
      STATUS_HUM_CRC  = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] temp_word;
      logic [15:0] hum_raw;
      status_type  status;
   } frame_rec_type;

   // CRC-8, MSB first, one byte
   function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   // floor(x / 65535) = (x + (x >> 16) + 1) >> 16, exact while the quotient stays small
   function automatic logic [15:0] div_65535(input logic [30:0] x);
      logic [31:0] s;
      s = 32'(x) + 32'(x[30:16]) + 32'd1;
      return s[31:16];
   endfunction

endpackage

// File: hdl/hfcd_front.sv
// Front end: takes frame bytes, tracks the byte position, runs the CRC checks
// and pushes one record per complete frame. Depends on hfcd_pkg.
module hfcd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] rx_byte
   input  logic                  req_tuser,   // [0] frame_start
   output logic                  push_valid,
   input  logic                  push_ready,
   output hfcd_pkg::frame_rec_type push_data
);

   logic [2:0]  pos_ff, pos_in, pos;
   logic [7:0]  crc_ff, crc_in, crc;
   logic        tgood_ff, tgood_in;
   logic [15:0] tword_ff, tword_in;
   logic [15:0] hword_ff, hword_in;
   logic        restart, accept;

   assign req_tready = push_ready;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      restart  = req_tuser | (pos_ff > hfcd_pkg::POS_H_CRC);
      pos      = restart ? hfcd_pkg::POS_T_HI : pos_ff;
      crc      = restart ? hfcd_pkg::CRC_INIT : crc_ff;
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      tgood_in = tgood_ff;
      tword_in = tword_ff;
      hword_in = hword_ff;
      push_valid = 1'b0;
      if (accept) begin
         pos_in = pos + 3'd1;
         crc_in = hfcd_pkg::crc_feed(crc, req_tdata);
         unique case (pos)
            hfcd_pkg::POS_T_HI: tword_in = {req_tdata, 8'h00};
            hfcd_pkg::POS_T_LO: tword_in = {tword_ff[15:8], req_tdata};
            hfcd_pkg::POS_T_CRC: begin
               tgood_in = (crc == req_tdata);
               crc_in   = hfcd_pkg::CRC_INIT;
            end
            hfcd_pkg::POS_H_HI: hword_in = {req_tdata, 8'h00};
            hfcd_pkg::POS_H_LO: hword_in = {hword_ff[15:8], req_tdata};
            hfcd_pkg::POS_H_CRC: begin
               crc_in     = hfcd_pkg::CRC_INIT;
               pos_in     = hfcd_pkg::POS_T_HI;
               push_valid = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      push_data.temp_word = tword_ff;
      push_data.hum_raw   = hword_ff;
      // temperature error wins when both words fail
      priority if (!tgood_ff)
         push_data.status = hfcd_pkg::STATUS_TEMP_CRC;
      else if (crc != req_tdata)
         push_data.status = hfcd_pkg::STATUS_HUM_CRC;
      else
         push_data.status = hfcd_pkg::STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= hfcd_pkg::POS_T_HI;
         crc_ff   <= hfcd_pkg::CRC_INIT;
         tgood_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         tgood_ff <= tgood_in;
      end
      tword_ff <= tword_in;
      hword_ff <= hword_in;
   end

endmodule

// File: hdl/hfcd_queue.sv
// Small record queue between front end and scaling back end.
// Depends on hfcd_pkg for the record type and depth.
module hfcd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  hfcd_pkg::frame_rec_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output hfcd_pkg::frame_rec_type pop_data
);

   hfcd_pkg::frame_rec_type slot_ff [hfcd_pkg::QUEUE_DEPTH];
   logic [hfcd_pkg::QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [hfcd_pkg::QUEUE_CW-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != hfcd_pkg::QUEUE_CW'(hfcd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: ;
      endcase
   end

   function automatic logic [hfcd_pkg::QUEUE_AW-1:0] next_ptr(
      input logic [hfcd_pkg::QUEUE_AW-1:0] p);
      return (p == hfcd_pkg::QUEUE_AW'(hfcd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         count_ff <= count_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: hdl/hfcd_back.sv
// Back end: scales raw words to centi-units in two stages (multiply, then
// divide by 65535 and offset) and holds the result in the output register.
// Depends on hfcd_pkg.
module hfcd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  hfcd_pkg::frame_rec_type pop_data,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
   output logic [1:0]              rsp_tuser    // [1:0] frame_status
);

   // stage 1: products
   logic                 s1_valid_ff;
   logic [30:0]          tprod_ff;
   logic [29:0]          hprod_ff;
   hfcd_pkg::status_type s1_status_ff;
   // stage 2: output register
   logic                 s2_valid_ff;
   logic [14:0]          temp_ff, temp_in;
   logic [13:0]          hum_ff, hum_in;
   hfcd_pkg::status_type s2_status_ff;

   logic s1_ready, s2_ready;
   logic [15:0] tq, hq;

   assign s2_ready  = ~s2_valid_ff | rsp_tready;
   assign s1_ready  = ~s1_valid_ff | s2_ready;
   assign pop_ready = s1_ready;

   always_comb begin
      tq = hfcd_pkg::div_65535(tprod_ff);
      hq = hfcd_pkg::div_65535({1'b0, hprod_ff});
      if (s1_status_ff == hfcd_pkg::STATUS_OK) begin
         temp_in = tq[14:0] - hfcd_pkg::TEMP_OFFSET;
         hum_in  = hq[13:0];
      end else begin
         temp_in = '0;
         hum_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= pop_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
      if (s1_ready && pop_valid) begin
         tprod_ff     <= 31'(pop_data.temp_word) * 31'(hfcd_pkg::TEMP_SCALE);
         hprod_ff     <= 30'(pop_data.hum_raw) * 30'(hfcd_pkg::HUM_SCALE);
         s1_status_ff <= pop_data.status;
      end
      if (s2_ready && s1_valid_ff) begin
         temp_ff      <= temp_in;
         hum_ff       <= hum_in;
         s2_status_ff <= s1_status_ff;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {3'b000, hum_ff, temp_ff};
   assign rsp_tuser  = s2_status_ff;

endmodule

// File: hdl/humidity_frame_crc_decoder.sv
// Top level of the humidity frame CRC decoder: front end, record queue, back end.
// Depends on hfcd_pkg, hfcd_front, hfcd_queue and hfcd_back.
//
// Usage:
//   req_* carries one frame byte per transfer: temperature high, low, CRC,
//   humidity high, low, CRC. req_tuser high marks a byte as the first of a
//   new frame and drops any partial frame; without it frames follow each
//   other every six bytes.
//   rsp_* carries one result per frame: temperature in 0.01 degC and
//   humidity in 0.01 %RH in tdata, frame status in tuser (ok, temperature
//   CRC error, humidity CRC error). Both values read zero on an error.
// Throughput: one byte per cycle while req_tready is high (combinational CRC
//   update); one result per cycle from the two-stage pipe while rsp_tready is high.
// Path: after the transfer of the sixth byte the record is written to the
//   queue, then passes the multiply stage, then the divide/offset stage
//   into the output register.
// Stall: when rsp_tready is low the result holds; the pipe and a two-entry
//   queue keep absorbing frames, and req_tready drops only when the queue
//   is full.
// Reset: synchronous; position returns to the first byte, CRC to 0xFF,
//   queue and pipe empty.
module humidity_frame_crc_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
   output logic [1:0]  rsp_tuser    // [1:0] frame_status
);

   logic                    push_valid, push_ready;
   hfcd_pkg::frame_rec_type push_data;
   logic                    pop_valid, pop_ready;
   hfcd_pkg::frame_rec_type pop_data;

   hfcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   hfcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   hfcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: hdl/hfcd_checker.sv
// Port-level checks for humidity_frame_crc_decoder, attached with bind.
// Depends on hfcd_pkg for status codes and value ranges.
module hfcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != 2'(hfcd_pkg::STATUS_OK)) |-> (rsp_tdata == '0))
      else $error("values not zero on CRC error");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == 2'(hfcd_pkg::STATUS_OK)) ||
                     (rsp_tuser == 2'(hfcd_pkg::STATUS_TEMP_CRC)) ||
                     (rsp_tuser == 2'(hfcd_pkg::STATUS_HUM_CRC)))
      else $error("unknown frame status");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[14:0]) >= 15'(hfcd_pkg::TEMP_MIN)) &&
                     ($signed(rsp_tdata[14:0]) <= 15'(hfcd_pkg::TEMP_MAX)))
      else $error("temperature out of range");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[28:15] <= 14'(hfcd_pkg::HUM_MAX)) && (rsp_tdata[31:29] == '0))
      else $error("humidity out of range");

endmodule

bind humidity_frame_crc_decoder hfcd_checker u_hfcd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
